### rtl/bnaw_pkg.sv
// Shared types, constants and microcode formats of the attractor walk block.
`timescale 1ns / 1ps
package bnaw_pkg;

  localparam int unsigned NUM_GENES  = 10;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned STATE_W    = 10;
  localparam int unsigned NUM_STATES = 1 << STATE_W;
  localparam int unsigned ROUND_W    = STATE_W + 1;
  localparam int unsigned STEP_W     = 3;

  typedef struct packed {
    logic [SLOT_W-1:0]  gene0_slot;
    logic [SLOT_W-1:0]  gene1_slot;
    logic [SLOT_W-1:0]  gene2_slot;
    logic [SLOT_W-1:0]  gene3_slot;
    logic [SLOT_W-1:0]  gene4_slot;
    logic [SLOT_W-1:0]  gene5_slot;
    logic [SLOT_W-1:0]  gene6_slot;
    logic [SLOT_W-1:0]  gene7_slot;
    logic [SLOT_W-1:0]  gene8_slot;
    logic [SLOT_W-1:0]  gene9_slot;
    logic [STATE_W-1:0] start_state;
  } req_t;

  typedef struct packed {
    logic [STATE_W-1:0] end_state;
    logic               outcome;
    logic [ROUND_W-1:0] rounds;
  } rsp_t;

  // Jump conditions of a control word: jump when true, else go to the next step.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_CLR_BUSY,
    C_SLOT_MORE,
    C_EQUAL,
    C_STOP
  } cond_e;

  typedef struct packed {
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              load;
    logic              clear;
    logic              record;
    logic              slot;
    logic              probe;
    logic              commit;
  } uword_t;

  typedef struct packed {
    logic start;
    logic clr_busy;
    logic slot_more;
    logic equal;
    logic stop;
  } status_t;

endpackage

### rtl/boolean_network_attractor_walk.sv
// Top level of the Boolean network attractor walk block.
//
// A request is taken at a rising clock edge with start high and busy low. It carries
// the update slot of each of the ten genes and the start state. busy stays high
// from the cycle after the request until the result appears. The result is shown
// on rsp_o for exactly one cycle with done_o high; the receiver cannot stall it,
// so it must take the result in that cycle.
//
// Steps: after the request edge, all 1024 entries of the visited map are swept clear
// through its single write port. Each round then runs a record step, k slot steps
// (at most 11, including the empty slot that ends it), a probe, a check and a next
// step. The last round ends after its check when it reaches a revisited state or the
// round count reaches the number of states, and after its probe when it reaches a
// fixed point. done_o is registered and rises as the sequencer returns to idle.
// The rate is set by the microcode loop over slots and rounds, one slot step per
// cycle, and by the visited map sweep. One request is worked on at a time; the
// next one can be taken at the edge that ends the done_o cycle.
//
// Reset puts the sequencer at its idle step with busy and done_o low. The visited
// map holds no reset value; it is cleared at the start of each request.
`timescale 1ns / 1ps
module boolean_network_attractor_walk
  import bnaw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  uword_t  uword;
  status_t status;

  bnaw_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .uword_o (uword),
    .busy_o  (busy)
  );

  bnaw_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req_i),
    .uword_i (uword),
    .status_o(status),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule

### rtl/bnaw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bnaw_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bnaw_useq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps
module bnaw_useq
  import bnaw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output uword_t  uword_o,
  output logic    busy_o
);

  localparam logic [STEP_W-1:0] S_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] S_CLEAR  = 3'd1;
  localparam logic [STEP_W-1:0] S_RECORD = 3'd2;
  localparam logic [STEP_W-1:0] S_SLOT   = 3'd3;
  localparam logic [STEP_W-1:0] S_PROBE  = 3'd4;
  localparam logic [STEP_W-1:0] S_CHECK  = 3'd5;
  localparam logic [STEP_W-1:0] S_NEXT   = 3'd6;

  // Fields: cond, target, load, clear, record, slot, probe, commit.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{C_ALWAYS, S_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    case (step)
      S_IDLE:   w = '{C_NO_START,  S_IDLE,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
      S_CLEAR:  w = '{C_CLR_BUSY,  S_CLEAR,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
      S_RECORD: w = '{C_NEVER,     S_IDLE,   1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
      S_SLOT:   w = '{C_SLOT_MORE, S_SLOT,   1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
      S_PROBE:  w = '{C_EQUAL,     S_IDLE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
      S_CHECK:  w = '{C_STOP,      S_IDLE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
      S_NEXT:   w = '{C_ALWAYS,    S_RECORD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
      default:  w = '{C_ALWAYS,    S_IDLE,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] upc_q, upc_d;
  uword_t            uw;
  logic              jump;

  assign uw = ucode(upc_q);

  always_comb begin
    case (uw.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_START:  jump = !status_i.start;
      C_CLR_BUSY:  jump = status_i.clr_busy;
      C_SLOT_MORE: jump = status_i.slot_more;
      C_EQUAL:     jump = status_i.equal;
      C_STOP:      jump = status_i.stop;
      default:     jump = 1'b1;
    endcase
    upc_d = jump ? uw.target : upc_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign uword_o = uw;
  assign busy_o  = (upc_q != S_IDLE);

endmodule

### rtl/bnaw_datapath.sv
// Datapath: gene rules, slot masks, visited map and result registers.
`timescale 1ns / 1ps
module bnaw_datapath
  import bnaw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  req_t    req_i,
  input  uword_t  uword_i,
  output status_t status_o,
  output logic    done_o,
  output rsp_t    rsp_o
);

  function automatic logic [STATE_W-1:0] rules(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] g;
    g[0] = s[8] | s[1] | s[3];
    g[1] = s[0] & ~(s[2] & s[8]);
    g[2] = (s[0] | (s[8] & s[9])) & ~(s[1] & s[4]);
    g[3] = (s[4] | s[3]) & ~s[9];
    g[4] = ((s[4] & s[5]) | s[3] | s[6] | (s[0] & s[1] & s[3])) & ~(s[8] | s[9]);
    g[5] = s[4] & ~s[8];
    g[6] = s[4];
    g[7] = s[3] | s[4];
    g[8] = (s[0] | s[9] | s[8] | s[2]) & ~(s[5] | s[7]);
    g[9] = (s[8] | s[9]) & ~(s[3] | (s[4] & s[0] & s[1]) | s[7]);
    return g;
  endfunction

  logic [SLOT_W-1:0]  slots_q [NUM_GENES];
  logic [STATE_W-1:0] cur_q, work_q, clr_q;
  logic [SLOT_W-1:0]  t_q;
  logic [ROUND_W-1:0] rounds_q;
  logic               done_q;
  rsp_t               rsp_q;

  logic [STATE_W-1:0] mask;
  logic               load, hit, full;
  logic               ram_we, ram_wdata, ram_rdata;
  logic [STATE_W-1:0] ram_waddr;

  assign load = uword_i.load && start_i;

  // Slot values at or above the gene count never update, so the slot walk ends there at the latest.
  always_comb begin
    for (int unsigned g = 0; g < NUM_GENES; g++) begin
      mask[g] = (slots_q[g] == t_q) && (t_q < SLOT_W'(NUM_GENES));
    end
  end

  assign ram_we    = uword_i.clear || uword_i.record;
  assign ram_waddr = uword_i.clear ? clr_q : cur_q;
  assign ram_wdata = !uword_i.clear;

  bnaw_ram #(
    .WIDTH(1),
    .DEPTH(NUM_STATES)
  ) u_visited (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(work_q),
    .rdata_o(ram_rdata)
  );

  assign hit  = ram_rdata;
  assign full = (rounds_q == ROUND_W'(NUM_STATES));

  assign status_o = '{
    start:     start_i,
    clr_busy:  !(&clr_q),
    slot_more: |mask,
    equal:     (work_q == cur_q),
    stop:      hit || full
  };

  always_ff @(posedge clk_i) begin
    if (load) begin
      slots_q[0] <= req_i.gene0_slot;
      slots_q[1] <= req_i.gene1_slot;
      slots_q[2] <= req_i.gene2_slot;
      slots_q[3] <= req_i.gene3_slot;
      slots_q[4] <= req_i.gene4_slot;
      slots_q[5] <= req_i.gene5_slot;
      slots_q[6] <= req_i.gene6_slot;
      slots_q[7] <= req_i.gene7_slot;
      slots_q[8] <= req_i.gene8_slot;
      slots_q[9] <= req_i.gene9_slot;
    end
    if (uword_i.record) begin
      work_q <= cur_q;
      t_q    <= '0;
    end else if (uword_i.slot) begin
      work_q <= (work_q & ~mask) | (rules(work_q) & mask);
      t_q    <= t_q + SLOT_W'(1);
    end
    if (uword_i.probe && (work_q == cur_q)) begin
      rsp_q <= '{end_state: cur_q, outcome: 1'b0, rounds: rounds_q};
    end else if (uword_i.commit) begin
      rsp_q <= '{end_state: work_q, outcome: hit, rounds: rounds_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      rounds_q <= '0;
      clr_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      if (load) begin
        cur_q    <= req_i.start_state;
        rounds_q <= '0;
      end else if (uword_i.commit) begin
        cur_q <= work_q;
      end else if (uword_i.record) begin
        rounds_q <= rounds_q + ROUND_W'(1);
      end
      // The sweep counter wraps back to zero, ready for the next request.
      if (uword_i.clear) begin
        clr_q <= clr_q + STATE_W'(1);
      end
      done_q <= (uword_i.probe && (work_q == cur_q)) || (uword_i.commit && (hit || full));
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### rtl/bnaw_checker.sv
// Port-level checks of the attractor walk block, bound to the top level.
`timescale 1ns / 1ps
module bnaw_checker
  import bnaw_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  // A result is only shown once the block has returned to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // An accepted request always makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // busy only drops together with a result.
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // The round count lies between one and the number of states.
  a_rounds_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.rounds != '0) && (rsp_o.rounds <= ROUND_W'(NUM_STATES)))
    else $error("round count out of range");

  // Each request first sweeps the visited map and runs at least one round, so done never directly follows it.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$past(start && !busy))
    else $error("result right after a request");

endmodule

bind boolean_network_attractor_walk bnaw_checker u_bnaw_checker (.*);
